### design/ika_pkg.sv
package ika_pkg;

   // datapath widths
   localparam int CW = 36;          // CORDIC x/y
   localparam int ZW = 26;          // angle accumulator, Q16 degrees
   localparam int SQW = 62;         // square root remainder/root
   localparam int NW = 50;          // cosine numerator magnitude
   localparam int DW = 48;          // cosine denominator
   localparam int QW = 30;          // cosine quotient bits

   localparam int DSQ_STEPS = 24;   // root bits of d
   localparam int DIV_STEPS = 30;
   localparam int ASQ_STEPS = 31;   // root bits of sin in Q30

   localparam int QDEPTH = 4;
   localparam int QAW = 2;

   localparam logic signed [ZW-1:0] DEG180_Q16 = ZW'(11796480);
   localparam logic signed [ZW-1:0] DEG90_Q16 = ZW'(5898240);
   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
   localparam logic signed [17:0] OUT_MAX = 18'sd46080;
   localparam logic signed [17:0] OUT_MIN = -18'sd46080;
   localparam logic signed [17:0] OUT_ZERO = 18'sd0;

   localparam logic [1:0] ST_IN_REACH = 2'd0;
   localparam logic [1:0] ST_MAX_REACH = 2'd1;
   localparam logic [1:0] ST_MIN_REACH = 2'd2;

   localparam logic REG_UPPER = 1'b0;
   localparam logic REG_LOWER = 1'b1;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [14:0] l1;
      logic [14:0] l2;
      logic [15:0] sum;
      logic [14:0] dif;
      logic [31:0] s;
      logic [1:0] status;
   } entry_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
   } cordic_type;

   typedef struct packed {
      logic [SQW-1:0] v;
      logic [SQW-1:0] r;
   } sq_type;

   typedef struct packed {
      logic [NW-1:0] n;
      logic [DW-1:0] den;
      logic [QW-1:0] q;
      logic neg;
      logic sat;
   } div_type;

   typedef struct packed {
      logic [1:0] st;
      logic base_zero;
      cordic_type bc;
      logic [15:0] sum;
      logic [14:0] dif;
      logic [22:0] a;
      logic [22:0] b;
      sq_type dsq;
      logic [23:0] d;
      logic [45:0] aa;
      logic [45:0] bb;
      logic [47:0] dd;
      logic [46:0] ad;
      logic [45:0] ab;
      div_type sdiv;
      div_type ediv;
      logic signed [31:0] s_c;
      logic signed [31:0] e_c;
      sq_type ssq;
      sq_type esq;
      cordic_type sc;
      cordic_type ec;
   } ctx_type;

   function automatic logic signed [ZW-1:0] atan_q16(int unsigned i);
      logic signed [ZW-1:0] t;
      case (i)
         0: t = ZW'(2949120);
         1: t = ZW'(1740967);
         2: t = ZW'(919879);
         3: t = ZW'(466945);
         4: t = ZW'(234379);
         5: t = ZW'(117304);
         6: t = ZW'(58666);
         7: t = ZW'(29335);
         8: t = ZW'(14668);
         9: t = ZW'(7334);
         10: t = ZW'(3667);
         11: t = ZW'(1833);
         12: t = ZW'(917);
         13: t = ZW'(458);
         14: t = ZW'(229);
         15: t = ZW'(115);
         16: t = ZW'(57);
         17: t = ZW'(29);
         18: t = ZW'(14);
         19: t = ZW'(7);
         20: t = ZW'(4);
         21: t = ZW'(2);
         22: t = ZW'(1);
         default: t = '0;
      endcase
      return t;
   endfunction

   // fold the left half plane onto the right one
   function automatic cordic_type cordic_init(logic signed [CW-1:0] x, logic signed [CW-1:0] y);
      cordic_type c;
      c.x = x;
      c.y = y;
      c.z = '0;
      if (x < 0) begin
         c.z = (y >= 0) ? DEG180_Q16 : -DEG180_Q16;
         c.x = -x;
         c.y = -y;
      end
      return c;
   endfunction

   function automatic cordic_type cordic_step(cordic_type c, int unsigned i);
      cordic_type n;
      logic signed [CW-1:0] sx;
      logic signed [CW-1:0] sy;
      sx = c.x >>> i;
      sy = c.y >>> i;
      if (c.y > 0) begin
         n.x = c.x + sy;
         n.y = c.y - sx;
         n.z = c.z + atan_q16(i);
      end else begin
         n.x = c.x - sy;
         n.y = c.y + sx;
         n.z = c.z - atan_q16(i);
      end
      return n;
   endfunction

   // one root digit, trial weight 4^k
   function automatic sq_type sqrt_step(sq_type s, int unsigned k);
      sq_type n;
      logic [SQW-1:0] b;
      logic [SQW-1:0] t;
      b = SQW'(1) << (2 * k);
      t = s.r + b;
      if (s.v >= t) begin
         n.v = s.v - t;
         n.r = (s.r >> 1) + b;
      end else begin
         n.v = s.v;
         n.r = s.r >> 1;
      end
      return n;
   endfunction

   function automatic div_type div_step(div_type d);
      div_type n;
      logic [NW-1:0] t;
      n = d;
      if (!d.sat) begin
         t = {d.n[NW-2:0], 1'b0};
         n.q = {d.q[QW-2:0], 1'b0};
         if (t >= NW'(d.den)) begin
            t = t - NW'(d.den);
            n.q[0] = 1'b1;
         end
         n.n = t;
      end
      return n;
   endfunction

   // round half up to 1/256 degree, then clamp
   function automatic logic signed [17:0] to_out(logic signed [ZW:0] q,
                                                 logic signed [17:0] lo,
                                                 logic signed [17:0] hi);
      logic signed [ZW:0] t;
      logic signed [17:0] r;
      t = (q + (ZW+1)'(128)) >>> 8;
      if (t < (ZW+1)'(lo)) begin
         r = lo;
      end else if (t > (ZW+1)'(hi)) begin
         r = hi;
      end else begin
         r = t[17:0];
      end
      return r;
   endfunction

endpackage

### design/ika_front.sv
module ika_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [31:0]          req_tdata,     // target_x, target_y
   input  logic [14:0]          upper_len,
   input  logic [14:0]          lower_len,
   input  logic                 q_full,
   output logic                 push,
   output ika_pkg::entry_type   push_entry
);

   logic v1_ff;
   logic signed [15:0] x1_ff;
   logic signed [15:0] y1_ff;
   logic [14:0] l1_ff;
   logic [14:0] l2_ff;

   logic v2_ff;
   ika_pkg::entry_type ent2_ff;
   ika_pkg::entry_type ent2_in;
   logic [31:0] sumsq_ff;
   logic [31:0] sumsq_in;
   logic [29:0] difsq_ff;
   logic [29:0] difsq_in;

   logic rdy2;
   logic signed [31:0] xx;
   logic signed [31:0] yy;

   assign rdy2 = !v2_ff || !q_full;
   assign req_tready = !v1_ff || rdy2;

   always_comb begin
      xx = 32'(x1_ff) * 32'(y1_ff - y1_ff + x1_ff);
      yy = 32'(y1_ff) * 32'(y1_ff);
      ent2_in.x = x1_ff;
      ent2_in.y = y1_ff;
      ent2_in.l1 = l1_ff;
      ent2_in.l2 = l2_ff;
      ent2_in.sum = 16'(l1_ff) + 16'(l2_ff);
      ent2_in.dif = (l1_ff > l2_ff) ? (l1_ff - l2_ff) : (l2_ff - l1_ff);
      ent2_in.s = $unsigned(xx) + $unsigned(yy);
      ent2_in.status = ika_pkg::ST_IN_REACH;
      sumsq_in = 32'(ent2_in.sum) * 32'(ent2_in.sum);
      difsq_in = 30'(ent2_in.dif) * 30'(ent2_in.dif);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            v1_ff <= req_tvalid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
      end
   end

   // a zero link register acts as one
   always_ff @(posedge clock) begin
      if (req_tready) begin
         x1_ff <= req_tdata[15:0];
         y1_ff <= req_tdata[31:16];
         l1_ff <= (upper_len == '0) ? 15'd1 : upper_len;
         l2_ff <= (lower_len == '0) ? 15'd1 : lower_len;
      end
      if (rdy2) begin
         ent2_ff <= ent2_in;
         sumsq_ff <= sumsq_in;
         difsq_ff <= difsq_in;
      end
   end

   always_comb begin
      push_entry = ent2_ff;
      if (ent2_ff.s > sumsq_ff) begin
         push_entry.status = ika_pkg::ST_MAX_REACH;
      end else if (ent2_ff.s < 32'(difsq_ff) || ent2_ff.s == '0) begin
         push_entry.status = ika_pkg::ST_MIN_REACH;
      end else begin
         push_entry.status = ika_pkg::ST_IN_REACH;
      end
   end

   assign push = v2_ff && !q_full;

   a_hold_when_full: assert property (@(posedge clock) disable iff (reset)
      v2_ff && q_full |=> v2_ff)
      else $error("front dropped a word while the queue was full");

endmodule

### design/ika_queue.sv
module ika_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ika_pkg::entry_type   push_entry,
   input  logic                 pop,
   output logic                 full,
   output logic                 empty,
   output ika_pkg::entry_type   head
);

   ika_pkg::entry_type mem_ff [ika_pkg::QDEPTH];
   logic [ika_pkg::QAW-1:0] wr_ff;
   logic [ika_pkg::QAW-1:0] rd_ff;
   logic [ika_pkg::QAW:0] cnt_ff;

   assign full = (cnt_ff == (ika_pkg::QAW+1)'(ika_pkg::QDEPTH));
   assign empty = (cnt_ff == '0);
   assign head = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue read while empty");

endmodule

### design/ika_back.sv
module ika_back #(
   parameter int ITERATIONS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ika_pkg::entry_type   head,
   input  logic                 q_empty,
   output logic                 pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [55:0]          rsp_tdata,     // base_angle, shoulder_angle, elbow_angle, pad
   output logic [1:0]           rsp_tuser      // reach_status
);

   localparam int ITER = (ITERATIONS > 32) ? 32 : ITERATIONS;
   localparam int LA = (ITER > ika_pkg::DSQ_STEPS) ? ITER : ika_pkg::DSQ_STEPS;
   localparam int P_MUL = LA + 1;
   localparam int P_NUM = LA + 2;
   localparam int P_DIV0 = LA + 3;
   localparam int P_QSQ = P_DIV0 + ika_pkg::DIV_STEPS;
   localparam int P_SQ0 = P_QSQ + 1;
   localparam int P_CI = P_SQ0 + ika_pkg::ASQ_STEPS;
   localparam int P_C0 = P_CI + 1;
   localparam int NST = P_C0 + ITER;

   ika_pkg::ctx_type ctx_ff [NST];
   ika_pkg::ctx_type stage_in [NST];
   logic [NST-1:0] valid_ff;
   logic en;

   logic rsp_valid_ff;
   logic signed [16:0] rsp_base_ff;
   logic [15:0] rsp_shoulder_ff;
   logic [15:0] rsp_elbow_ff;
   logic [1:0] rsp_status_ff;
   logic signed [17:0] base_in;
   logic signed [17:0] shoulder_in;
   logic signed [17:0] elbow_in;

   // the whole pipe advances unless a finished word is stuck at the output
   assign en = !rsp_valid_ff || rsp_tready;
   assign pop = en && !q_empty;

   for (genvar j = 0; j < NST; j++) begin : g_stage
      if (j == 0) begin : g_entry
         always_comb begin
            stage_in[j] = '0;
            stage_in[j].st = head.status;
            stage_in[j].base_zero = (head.x == '0) && (head.y == '0);
            stage_in[j].bc = ika_pkg::cordic_init({{(ika_pkg::CW-32){head.x[15]}}, head.x, 16'b0},
                                                  {{(ika_pkg::CW-32){head.y[15]}}, head.y, 16'b0});
            stage_in[j].sum = head.sum;
            stage_in[j].dif = head.dif;
            stage_in[j].a = {head.l1, 8'b0};
            stage_in[j].b = {head.l2, 8'b0};
            stage_in[j].dsq.v = ika_pkg::SQW'({head.s, 16'b0});
            stage_in[j].dsq.r = '0;
         end
      end else if (j <= LA) begin : g_base
         // base yaw iterations run beside the digits of d
         always_comb begin
            stage_in[j] = ctx_ff[j-1];
            if (j - 1 < ITER) begin
               stage_in[j].bc = ika_pkg::cordic_step(ctx_ff[j-1].bc, j - 1);
            end
            if (j - 1 < ika_pkg::DSQ_STEPS) begin
               stage_in[j].dsq = ika_pkg::sqrt_step(ctx_ff[j-1].dsq,
                                                    ika_pkg::DSQ_STEPS - j);
            end
         end
      end else if (j == P_MUL) begin : g_mul
         always_comb begin
            logic [23:0] dsel;
            case (ctx_ff[j-1].st)
               ika_pkg::ST_MAX_REACH: dsel = {ctx_ff[j-1].sum, 8'b0};
               ika_pkg::ST_MIN_REACH: dsel = {1'b0, ctx_ff[j-1].dif, 8'b0};
               default: dsel = ctx_ff[j-1].dsq.r[23:0];
            endcase
            stage_in[j] = ctx_ff[j-1];
            stage_in[j].d = dsel;
            stage_in[j].aa = 46'(ctx_ff[j-1].a) * 46'(ctx_ff[j-1].a);
            stage_in[j].bb = 46'(ctx_ff[j-1].b) * 46'(ctx_ff[j-1].b);
            stage_in[j].dd = 48'(dsel) * 48'(dsel);
            stage_in[j].ad = 47'(ctx_ff[j-1].a) * 47'(dsel);
            stage_in[j].ab = 46'(ctx_ff[j-1].a) * 46'(ctx_ff[j-1].b);
         end
      end else if (j == P_NUM) begin : g_num
         always_comb begin
            logic signed [ika_pkg::NW-1:0] ns;
            logic signed [ika_pkg::NW-1:0] ne;
            ns = $signed({4'b0, ctx_ff[j-1].aa}) + $signed({2'b0, ctx_ff[j-1].dd})
                 - $signed({4'b0, ctx_ff[j-1].bb});
            ne = $signed({4'b0, ctx_ff[j-1].aa}) + $signed({4'b0, ctx_ff[j-1].bb})
                 - $signed({2'b0, ctx_ff[j-1].dd});
            stage_in[j] = ctx_ff[j-1];
            stage_in[j].sdiv.neg = ns < 0;
            stage_in[j].sdiv.n = (ns < 0) ? $unsigned(-ns) : $unsigned(ns);
            stage_in[j].sdiv.den = {ctx_ff[j-1].ad, 1'b0};
            stage_in[j].sdiv.q = '0;
            stage_in[j].sdiv.sat = stage_in[j].sdiv.n >= ika_pkg::NW'(stage_in[j].sdiv.den);
            stage_in[j].ediv.neg = ne < 0;
            stage_in[j].ediv.n = (ne < 0) ? $unsigned(-ne) : $unsigned(ne);
            stage_in[j].ediv.den = {1'b0, ctx_ff[j-1].ab, 1'b0};
            stage_in[j].ediv.q = '0;
            stage_in[j].ediv.sat = stage_in[j].ediv.n >= ika_pkg::NW'(stage_in[j].ediv.den);
         end
      end else if (j < P_QSQ) begin : g_div
         always_comb begin
            stage_in[j] = ctx_ff[j-1];
            stage_in[j].sdiv = ika_pkg::div_step(ctx_ff[j-1].sdiv);
            stage_in[j].ediv = ika_pkg::div_step(ctx_ff[j-1].ediv);
         end
      end else if (j == P_QSQ) begin : g_qsq
         // sin = sqrt(1 - cos^2) in Q30
         always_comb begin
            logic [30:0] qs;
            logic [30:0] qe;
            qs = ctx_ff[j-1].sdiv.sat ? ika_pkg::ONE_Q30 : {1'b0, ctx_ff[j-1].sdiv.q};
            qe = ctx_ff[j-1].ediv.sat ? ika_pkg::ONE_Q30 : {1'b0, ctx_ff[j-1].ediv.q};
            stage_in[j] = ctx_ff[j-1];
            stage_in[j].s_c = ctx_ff[j-1].sdiv.neg ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
            stage_in[j].e_c = ctx_ff[j-1].ediv.neg ? -$signed({1'b0, qe}) : $signed({1'b0, qe});
            stage_in[j].ssq.v = (ika_pkg::SQW'(1) << 60) - ika_pkg::SQW'(qs) * ika_pkg::SQW'(qs);
            stage_in[j].ssq.r = '0;
            stage_in[j].esq.v = (ika_pkg::SQW'(1) << 60) - ika_pkg::SQW'(qe) * ika_pkg::SQW'(qe);
            stage_in[j].esq.r = '0;
         end
      end else if (j < P_CI) begin : g_sqrt
         always_comb begin
            stage_in[j] = ctx_ff[j-1];
            stage_in[j].ssq = ika_pkg::sqrt_step(ctx_ff[j-1].ssq, P_CI - 1 - j);
            stage_in[j].esq = ika_pkg::sqrt_step(ctx_ff[j-1].esq, P_CI - 1 - j);
         end
      end else if (j == P_CI) begin : g_cinit
         always_comb begin
            stage_in[j] = ctx_ff[j-1];
            stage_in[j].sc = ika_pkg::cordic_init(ika_pkg::CW'(ctx_ff[j-1].s_c),
                                $signed({{(ika_pkg::CW-31){1'b0}}, ctx_ff[j-1].ssq.r[30:0]}));
            stage_in[j].ec = ika_pkg::cordic_init(ika_pkg::CW'(ctx_ff[j-1].e_c),
                                $signed({{(ika_pkg::CW-31){1'b0}}, ctx_ff[j-1].esq.r[30:0]}));
         end
      end else begin : g_acos
         always_comb begin
            stage_in[j] = ctx_ff[j-1];
            stage_in[j].sc = ika_pkg::cordic_step(ctx_ff[j-1].sc, j - P_C0);
            stage_in[j].ec = ika_pkg::cordic_step(ctx_ff[j-1].ec, j - P_C0);
         end
      end
   end

   always_comb begin
      base_in = ctx_ff[NST-1].base_zero ? ika_pkg::OUT_ZERO :
                ika_pkg::to_out({ctx_ff[NST-1].bc.z[ika_pkg::ZW-1], ctx_ff[NST-1].bc.z},
                                ika_pkg::OUT_MIN, ika_pkg::OUT_MAX);
      // zero distance takes the limit, a right angle
      if (ctx_ff[NST-1].d == '0) begin
         shoulder_in = ika_pkg::to_out({ika_pkg::DEG90_Q16[ika_pkg::ZW-1], ika_pkg::DEG90_Q16},
                                       ika_pkg::OUT_ZERO, ika_pkg::OUT_MAX);
      end else begin
         shoulder_in = ika_pkg::to_out({ctx_ff[NST-1].sc.z[ika_pkg::ZW-1], ctx_ff[NST-1].sc.z},
                                       ika_pkg::OUT_ZERO, ika_pkg::OUT_MAX);
      end
      elbow_in = ika_pkg::to_out({ika_pkg::DEG180_Q16[ika_pkg::ZW-1], ika_pkg::DEG180_Q16}
                                 - {ctx_ff[NST-1].ec.z[ika_pkg::ZW-1], ctx_ff[NST-1].ec.z},
                                 ika_pkg::OUT_ZERO, ika_pkg::OUT_MAX);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= {valid_ff[NST-2:0], pop};
         rsp_valid_ff <= valid_ff[NST-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctx_ff <= stage_in;
         rsp_base_ff <= base_in[16:0];
         rsp_shoulder_ff <= shoulder_in[15:0];
         rsp_elbow_ff <= elbow_in[15:0];
         rsp_status_ff <= ctx_ff[NST-1].st;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {7'b0, rsp_elbow_ff, rsp_shoulder_ff, rsp_base_ff};
   assign rsp_tuser = rsp_status_ff;

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(valid_ff))
      else $error("pipeline moved while the output was stalled");

endmodule

### design/two_link_arm_inverse_kinematics.sv
// Latency from accept to rsp_tvalid is set by the CORDIC, square root and divider stages
//   in series.
// Throughput: one word per cycle while rsp_tready is high; each back stage is a register.
// A four-word queue separates the classifying front from the arithmetic back.
// Reset: synchronous, active high; clears all valid state and loads both link
//   lengths with 2560.
module two_link_arm_inverse_kinematics #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,     // target_x, target_y
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,     // base_angle, shoulder_angle, elbow_angle, zero pad
   output logic [1:0]  rsp_tuser,     // reach_status
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [14:0] csr_data
);

   logic [14:0] upper_ff;
   logic [14:0] lower_ff;

   logic q_full;
   logic q_empty;
   logic push;
   logic pop;
   ika_pkg::entry_type push_entry;
   ika_pkg::entry_type head;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff <= 15'd2560;
         lower_ff <= 15'd2560;
      end else if (csr_valid) begin
         case (csr_index)
            ika_pkg::REG_UPPER: upper_ff <= csr_data;
            ika_pkg::REG_LOWER: lower_ff <= csr_data;
            default: ;
         endcase
      end
   end

   ika_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .upper_len  (upper_ff),
      .lower_len  (lower_ff),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   ika_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (q_full),
      .empty      (q_empty),
      .head       (head)
   );

   ika_back #(
      .ITERATIONS (CORDIC_ITERATIONS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_empty    (q_empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
